// ----- sv/bhte_pkg.sv -----
// ----------------------------------------------------------------------------
// Bounded hash table engine: shared package
// Table size, field widths, command and status codes, the controller to
// datapath command and status words, and the bucket hash helpers.
// ----------------------------------------------------------------------------
package bhte_pkg;

   // Table geometry
   localparam int TABLE_SIZE = 12;
   localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int KEY_W    = 16;
   localparam int STATUS_W = 2;
   localparam int BUCKET_W = 4;

   // Hash sum: key plus offset, one bit wider than the key
   localparam int HSUM_W = KEY_W + 1;

   // Weighted bit sum is below HSUM_W * TABLE_SIZE
   localparam int SUM_W = $clog2(HSUM_W * (TABLE_SIZE - 1) + 1);

   // Remainder register: holds a slot index and covers the bucket field
   localparam int REM_W = (IDX_W > BUCKET_W) ? IDX_W : BUCKET_W;

   // Reciprocal for the final reduction, exact for sums below 2**SUM_W
   localparam int RECIP_SHIFT = 20;
   localparam int PROD_W      = SUM_W + RECIP_SHIFT + 1;

   typedef logic [IDX_W-1:0]       idx_type;
   typedef logic [CMD_W-1:0]       cmd_type;
   typedef logic [KEY_W-1:0]       key_type;
   typedef logic [STATUS_W-1:0]    status_type;
   typedef logic [BUCKET_W-1:0]    bucket_type;
   typedef logic [HSUM_W-1:0]      hsum_type;
   typedef logic [SUM_W-1:0]       sum_type;
   typedef logic [REM_W-1:0]       rem_type;
   typedef logic [PROD_W-1:0]      prod_type;
   typedef logic [TABLE_SIZE-1:0]  valid_type;

   localparam hsum_type HASH_OFFSET = hsum_type'(1479);
   localparam prod_type RECIP =
      prod_type'(((1 << RECIP_SHIFT) + TABLE_SIZE - 1) / TABLE_SIZE);
   localparam sum_type  TABLE_SIZE_SUM = sum_type'(TABLE_SIZE);
   localparam idx_type  LAST_IDX       = idx_type'(TABLE_SIZE - 1);

   // Command codes
   localparam cmd_type CMD_FIND   = 2'd0;
   localparam cmd_type CMD_INSERT = 2'd1;
   localparam cmd_type CMD_DELETE = 2'd2;

   // Status codes
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NOT_FOUND = 2'd1;
   localparam status_type STATUS_FULL      = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic load;     // take a new word
      logic read;     // read the slot at the scan address and advance
      logic commit;   // update the table and issue the response
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_last;   // scan address is on the last slot
   } dp_status_type;

   // Weight of bit pos of the hash sum: 2**pos mod TABLE_SIZE
   function automatic sum_type bit_weight(input int pos);
      int w;
      w = 1 % TABLE_SIZE;
      for (int j = 0; j < pos; j++) begin
         w = (w * 2) % TABLE_SIZE;
      end
      return sum_type'(w);
   endfunction

endpackage

// ----- sv/bounded_hash_table_engine_core.sv -----
// ----------------------------------------------------------------------------
// Bounded hash table engine
// Find, insert and delete of 16-bit keys in a twelve slot table, with the
// bucket index (1479 + key) mod table size reported on every command.
// ----------------------------------------------------------------------------
//
//   channel   handshake          payload
//   request   start / busy       req_cmd, req_key
//   response  rsp_valid strobe   rsp_status, rsp_bucket
//
// A command is taken when start is high and busy is low. It passes through
// load of the word, a read of each slot from the key memory over its single
// read port, the last compare and commit; the response strobe follows
// commit, and a new command may be taken in that cycle. Synchronous reset
// empties the table at once. The response is shown for one cycle and cannot
// be stalled.
//
module bounded_hash_table_engine_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  bhte_pkg::cmd_type    req_cmd,
   input  bhte_pkg::key_type    req_key,
   output logic                 rsp_valid,
   output bhte_pkg::status_type rsp_status,
   output bhte_pkg::bucket_type rsp_bucket
);

   bhte_pkg::dp_cmd_type    dp_cmd;
   bhte_pkg::dp_status_type dp_status;

   // Sequence each word
   bhte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   // Hold the table and build responses
   bhte_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status),
      .req_cmd    (req_cmd),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_bucket (rsp_bucket)
   );

endmodule

// ----- sv/bhte_ctrl.sv -----
// ----------------------------------------------------------------------------
// Bounded hash table engine: controller
// Sequences one command: load, slot scan, drain of the last compare, commit.
// ----------------------------------------------------------------------------
module bhte_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output bhte_pkg::dp_cmd_type    dp_cmd,
   input  bhte_pkg::dp_status_type dp_status
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and datapath commands
   always_comb begin
      state_in      = state_ff;
      dp_cmd.load   = 1'b0;
      dp_cmd.read   = 1'b0;
      dp_cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dp_cmd.load = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            dp_cmd.read = 1'b1;
            if (dp_status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            dp_cmd.commit = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- sv/bhte_datapath.sv -----
// ----------------------------------------------------------------------------
// Bounded hash table engine: datapath
// Slot key memory, slot valid bits, scan compare, bucket hash pipeline and
// the response register.
// ----------------------------------------------------------------------------
module bhte_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  bhte_pkg::dp_cmd_type    dp_cmd,
   output bhte_pkg::dp_status_type dp_status,
   input  bhte_pkg::cmd_type       req_cmd,
   input  bhte_pkg::key_type       req_key,
   output logic                    rsp_valid,
   output bhte_pkg::status_type    rsp_status,
   output bhte_pkg::bucket_type    rsp_bucket
);

   // Slot key memory
   bhte_pkg::key_type    slot_key_ff [bhte_pkg::TABLE_SIZE];
   bhte_pkg::valid_type  slot_valid_ff, slot_valid_in;

   // Command word
   bhte_pkg::cmd_type    cmd_ff, cmd_in;
   bhte_pkg::key_type    key_ff, key_in;

   // Scan
   bhte_pkg::idx_type    addr_ff, addr_in;
   bhte_pkg::idx_type    rd_addr_ff;
   bhte_pkg::key_type    rd_key_ff;
   logic                 rd_pend_ff;
   logic                 hit_ff, hit_in;
   bhte_pkg::idx_type    hit_idx_ff, hit_idx_in;
   logic                 match;

   // Free slot search
   bhte_pkg::idx_type    free_idx;
   logic                 free_any;

   // Bucket pipeline
   bhte_pkg::hsum_type   hsum_ff, hsum_in;
   bhte_pkg::sum_type    sum_lo_ff, sum_lo_in;
   bhte_pkg::sum_type    sum_hi_ff, sum_hi_in;
   bhte_pkg::sum_type    sum_ff, sum_in;
   bhte_pkg::sum_type    sum_q_ff;
   bhte_pkg::sum_type    quot_ff, quot_in;
   bhte_pkg::prod_type   prod;
   bhte_pkg::rem_type    rem_ff, rem_in;

   // Response
   logic                 rsp_valid_ff, rsp_valid_in;
   bhte_pkg::status_type rsp_status_ff, rsp_status_in;
   bhte_pkg::bucket_type rsp_bucket_ff, rsp_bucket_in;

   logic                 do_write;

   // Latch the command word
   assign cmd_in = dp_cmd.load ? req_cmd : cmd_ff;
   assign key_in = dp_cmd.load ? req_key : key_ff;

   // Advance the scan address
   always_comb begin
      addr_in = addr_ff;
      if (dp_cmd.load) begin
         addr_in = '0;
      end else if (dp_cmd.read) begin
         addr_in = addr_ff + bhte_pkg::idx_type'(1);
      end
   end

   assign dp_status.scan_last = (addr_ff == bhte_pkg::LAST_IDX);

   // Compare the slot read last cycle; keep the lowest hit
   assign match = rd_pend_ff && slot_valid_ff[rd_addr_ff] && (rd_key_ff == key_ff);

   always_comb begin
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      if (dp_cmd.load) begin
         hit_in = 1'b0;
      end else if (match && !hit_ff) begin
         hit_in     = 1'b1;
         hit_idx_in = rd_addr_ff;
      end
   end

   // Find the lowest free slot
   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int i = bhte_pkg::TABLE_SIZE - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_idx = bhte_pkg::idx_type'(i);
            free_any = 1'b1;
         end
      end
   end

   // Update valid bits and build the status on commit
   always_comb begin
      slot_valid_in = slot_valid_ff;
      do_write      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_valid_in  = dp_cmd.commit;
      if (dp_cmd.commit) begin
         rsp_bucket_in = rem_ff[bhte_pkg::BUCKET_W-1:0];
         case (cmd_ff)
            bhte_pkg::CMD_INSERT: begin
               if (free_any) begin
                  do_write                = 1'b1;
                  slot_valid_in[free_idx] = 1'b1;
                  rsp_status_in           = bhte_pkg::STATUS_OK;
               end else begin
                  rsp_status_in = bhte_pkg::STATUS_FULL;
               end
            end
            bhte_pkg::CMD_DELETE: begin
               if (hit_ff) begin
                  slot_valid_in[hit_idx_ff] = 1'b0;
                  rsp_status_in             = bhte_pkg::STATUS_OK;
               end else begin
                  rsp_status_in = bhte_pkg::STATUS_NOT_FOUND;
               end
            end
            default: begin
               rsp_status_in = hit_ff ? bhte_pkg::STATUS_OK : bhte_pkg::STATUS_NOT_FOUND;
            end
         endcase
      end
   end

   // Bucket: add offset, fold bits by their weights mod table size, reduce
   assign hsum_in = bhte_pkg::hsum_type'(key_ff) + bhte_pkg::HASH_OFFSET;

   always_comb begin
      sum_lo_in = '0;
      sum_hi_in = '0;
      for (int i = 0; i < bhte_pkg::HSUM_W / 2; i++) begin
         if (hsum_ff[i]) begin
            sum_lo_in = sum_lo_in + bhte_pkg::bit_weight(i);
         end
      end
      for (int i = bhte_pkg::HSUM_W / 2; i < bhte_pkg::HSUM_W; i++) begin
         if (hsum_ff[i]) begin
            sum_hi_in = sum_hi_in + bhte_pkg::bit_weight(i);
         end
      end
   end

   assign sum_in  = sum_lo_ff + sum_hi_ff;
   assign prod    = bhte_pkg::prod_type'(sum_ff) * bhte_pkg::RECIP;
   assign quot_in = prod[bhte_pkg::RECIP_SHIFT +: bhte_pkg::SUM_W];
   assign rem_in  = bhte_pkg::rem_type'(sum_q_ff - quot_ff * bhte_pkg::TABLE_SIZE_SUM);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         rd_pend_ff    <= dp_cmd.read;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      addr_ff       <= addr_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hsum_ff       <= hsum_in;
      sum_lo_ff     <= sum_lo_in;
      sum_hi_ff     <= sum_hi_in;
      sum_ff        <= sum_in;
      sum_q_ff      <= sum_ff;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bucket_ff <= rsp_bucket_in;
   end

   // Read the slot memory
   always_ff @(posedge clock) begin
      if (dp_cmd.read) begin
         rd_key_ff  <= slot_key_ff[addr_ff];
         rd_addr_ff <= addr_ff;
      end
   end

   // Write the slot memory
   always_ff @(posedge clock) begin
      if (do_write) begin
         slot_key_ff[free_idx] <= key_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_bucket = rsp_bucket_ff;

endmodule
